// File: rtl/coo_sparse_entry_table_unit_assert.svh
// Assertion macros for the sparse entry table RTL, included by the scan sequencer.
`ifndef COO_SPARSE_ENTRY_TABLE_UNIT_ASSERT_SVH
`define COO_SPARSE_ENTRY_TABLE_UNIT_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define COO_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define COO_ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication.
`define COO_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// File: rtl/coo_pkg.sv
// Types and constants of the sparse entry table.
package coo_pkg;

  localparam int CAPACITY_DEF   = 256;
  localparam int INDEX_BITS_DEF = 16;
  localparam int ROW_W          = 16;
  localparam int VALUE_W        = 64;
  localparam int COUNT_W        = 9;

  // Request codes
  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_SET = 1'b1;

  typedef struct packed {
    logic               action;
    logic [ROW_W-1:0]   row;
    logic [ROW_W-1:0]   col;
    logic [VALUE_W-1:0] write_value;
  } req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] read_value;
    logic               found;
    logic               table_full;
    logic [COUNT_W-1:0] entry_count;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

// File: rtl/coo_sparse_entry_table_unit.sv
// Sparse matrix entry table: each item scans the stored entries one per cycle.
// Each entry read returns registered data that is compared with the key; a hit
// or reaching the entry count ends the scan, then the result waits for the output.
// A new item is accepted only once the result of the last one is registered.
// Reset clears the entry count and the result valid flag; the entry RAM is not
// cleared and needs no clearing pass, since only entries below count are read.
module coo_sparse_entry_table_unit #(
  parameter int CAPACITY   = coo_pkg::CAPACITY_DEF,
  parameter int INDEX_BITS = coo_pkg::INDEX_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  coo_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output coo_pkg::rsp_t rsp
);

  localparam int AW      = $clog2(CAPACITY);
  localparam int KEY_W   = (INDEX_BITS < coo_pkg::ROW_W) ? INDEX_BITS : coo_pkg::ROW_W;
  localparam int ENTRY_W = 2 * KEY_W + coo_pkg::VALUE_W;

  logic [AW-1:0]      mem_raddr, mem_waddr;
  logic [ENTRY_W-1:0] mem_rdata, mem_wdata;
  logic               mem_we;

  // scan sequencer
  coo_ctrl #(
    .CAPACITY   (CAPACITY),
    .INDEX_BITS (INDEX_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata)
  );

  // entry store
  coo_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// File: rtl/coo_ram.sv
// Entry store: one write port, one read port with registered read data.
module coo_ram #(
  parameter int DEPTH = coo_pkg::CAPACITY_DEF,
  parameter int WIDTH = 2 * coo_pkg::ROW_W + coo_pkg::VALUE_W
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/coo_ctrl.sv
// Scan sequencer: streams stored entries, matches keys, updates or appends.
module coo_ctrl #(
  parameter int CAPACITY   = coo_pkg::CAPACITY_DEF,
  parameter int INDEX_BITS = coo_pkg::INDEX_BITS_DEF,
  localparam int AW        = $clog2(CAPACITY),
  localparam int KEY_W     = (INDEX_BITS < coo_pkg::ROW_W) ? INDEX_BITS : coo_pkg::ROW_W,
  localparam int ENTRY_W   = 2 * KEY_W + coo_pkg::VALUE_W
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  coo_pkg::req_t       req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output coo_pkg::rsp_t       rsp,
  output logic [AW-1:0]       mem_raddr,
  input  logic [ENTRY_W-1:0]  mem_rdata,
  output logic                mem_we,
  output logic [AW-1:0]       mem_waddr,
  output logic [ENTRY_W-1:0]  mem_wdata
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int VW = coo_pkg::VALUE_W;

  coo_pkg::state_t state, state_next;
  logic [CW-1:0]   count, count_next;
  logic [CW-1:0]   idx, idx_next;
  logic            pend, pend_next;
  logic [AW-1:0]   raddr_q, raddr_next;
  logic            hit, hit_next;
  logic [AW-1:0]   hit_addr, hit_addr_next;
  logic [VW-1:0]   hit_value, hit_value_next;
  coo_pkg::req_t   req_q, req_next;
  coo_pkg::rsp_t   rsp_q, rsp_next;
  logic            rsp_valid_next;

  logic [KEY_W-1:0] key_row, key_col;
  logic             match, is_set, room, out_free, append_fire;

  assign key_row  = req_q.row[KEY_W-1:0];
  assign key_col  = req_q.col[KEY_W-1:0];
  assign match    = (mem_rdata[ENTRY_W-1 -: KEY_W] == key_row) &&
                    (mem_rdata[VW+KEY_W-1 -: KEY_W] == key_col);
  assign is_set   = (req_q.action == coo_pkg::ACT_SET);
  assign room     = (count < CW'(CAPACITY));
  assign out_free = !rsp_valid || !rsp_stall;
  assign append_fire = (state == coo_pkg::ST_DONE) && out_free && is_set && !hit && room;

  assign req_stall = (state != coo_pkg::ST_IDLE);
  assign mem_raddr = idx[AW-1:0];
  assign rsp       = rsp_q;

  // next state, memory writes and result
  always_comb begin
    logic [CW+8:0] cnt_ext;
    state_next     = state;
    count_next     = count;
    idx_next       = idx;
    pend_next      = 1'b0;
    raddr_next     = raddr_q;
    hit_next       = hit;
    hit_addr_next  = hit_addr;
    hit_value_next = hit_value;
    req_next       = req_q;
    rsp_next       = rsp_q;
    rsp_valid_next = rsp_valid;
    mem_we         = 1'b0;
    mem_waddr      = hit_addr;
    mem_wdata      = {key_row, key_col, req_q.write_value};
    cnt_ext        = '0;

    if (rsp_valid && !rsp_stall) begin
      rsp_valid_next = 1'b0;
    end

    case (state)
      coo_pkg::ST_IDLE: begin
        if (req_valid) begin
          req_next   = req;
          idx_next   = '0;
          state_next = coo_pkg::ST_SCAN;
        end
      end
      coo_pkg::ST_SCAN: begin
        // one read issued per cycle, compare the one that came back
        if (pend && match) begin
          hit_next       = 1'b1;
          hit_addr_next  = raddr_q;
          hit_value_next = mem_rdata[VW-1:0];
          state_next     = coo_pkg::ST_DONE;
        end else if (idx == count) begin
          hit_next   = 1'b0;
          state_next = coo_pkg::ST_DONE;
        end else begin
          pend_next  = 1'b1;
          raddr_next = idx[AW-1:0];
          idx_next   = idx + CW'(1);
        end
      end
      coo_pkg::ST_DONE: begin
        if (out_free) begin
          if (is_set && hit) begin
            mem_we    = 1'b1;
            mem_waddr = hit_addr;
          end else if (append_fire) begin
            mem_we     = 1'b1;
            mem_waddr  = count[AW-1:0];
            count_next = count + CW'(1);
          end
          cnt_ext              = {9'd0, count_next};
          rsp_next.read_value  = (!is_set && hit) ? hit_value : '0;
          rsp_next.found       = hit;
          rsp_next.table_full  = is_set && !hit && !room;
          rsp_next.entry_count = cnt_ext[8:0];
          rsp_valid_next       = 1'b1;
          state_next           = coo_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = coo_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= coo_pkg::ST_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      pend      <= pend_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx       <= idx_next;
    raddr_q   <= raddr_next;
    hit       <= hit_next;
    hit_addr  <= hit_addr_next;
    hit_value <= hit_value_next;
    req_q     <= req_next;
    rsp_q     <= rsp_next;
  end

`include "coo_sparse_entry_table_unit_assert.svh"

  `COO_ASSERT(a_count_bound, count <= CW'(CAPACITY), "entry count above capacity")
  `COO_ASSERT_IMPL(a_scan_bound, state == coo_pkg::ST_SCAN, idx <= count, "scan ran past count")
  `COO_ASSERT_IMPL(a_read_below_count, pend, raddr_q < count, "read of an entry at or above count")
  `COO_ASSERT_NEXT(a_append_step, append_fire, count == $past(count) + CW'(1), "append did not bump count")

endmodule

// File: sim/tb.sv
// Self-checking testbench for the sparse matrix entry table unit.
module tb;

  localparam int CAP         = coo_pkg::CAPACITY_DEF;
  localparam int RW          = coo_pkg::ROW_W;
  localparam int VW          = coo_pkg::VALUE_W;
  localparam int CNT_W       = coo_pkg::COUNT_W;
  localparam int REQ_W       = $bits(coo_pkg::req_t);
  localparam int POOL_N      = 48;
  localparam int HOLD_CYCLES = 600;
  localparam int IDLE_LIMIT  = 5000;
  localparam int SETTLE_CYC  = CAP + 40;

  logic          clk;
  logic          rst       = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_stall;
  coo_pkg::req_t req       = '0;
  logic          rsp_valid;
  logic          rsp_stall = 1'b0;
  coo_pkg::rsp_t rsp;

  coo_sparse_entry_table_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // Shadow copy of the entry table
  logic [RW-1:0] tbl_row [CAP];
  logic [RW-1:0] tbl_col [CAP];
  logic [VW-1:0] tbl_val [CAP];
  int            tbl_cnt = 0;

  coo_pkg::rsp_t expected_rsp_q [$];
  int            error_cnt = 0;

  // Coordinates reused so that gets and sets hit stored entries
  logic [RW-1:0] pool_row [POOL_N];
  logic [RW-1:0] pool_col [POOL_N];

  // Idling knobs and the long receiver hold-off
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_req_cnt  = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Looks up the coordinate, applies a set, returns the answer for one item
  function automatic coo_pkg::rsp_t predict_access(coo_pkg::req_t a);
    coo_pkg::rsp_t o;
    int            hit_idx;
    int            k;
    o = '0;
    hit_idx = -1;
    for (k = 0; k < tbl_cnt && hit_idx < 0; k++) begin
      if (tbl_row[k] == a.row && tbl_col[k] == a.col) hit_idx = k;
    end
    if (hit_idx >= 0) begin
      o.found = 1'b1;
      if (a.action == coo_pkg::ACT_SET) tbl_val[hit_idx] = a.write_value;
      else o.read_value = tbl_val[hit_idx];
    end else if (a.action == coo_pkg::ACT_SET) begin
      if (tbl_cnt < CAP) begin
        tbl_row[tbl_cnt] = a.row;
        tbl_col[tbl_cnt] = a.col;
        tbl_val[tbl_cnt] = a.write_value;
        tbl_cnt++;
      end else begin
        o.table_full = 1'b1;
      end
    end
    o.entry_count = CNT_W'(tbl_cnt);
    return o;
  endfunction

  function automatic coo_pkg::req_t mk_access(logic act, logic [RW-1:0] r, logic [RW-1:0] c,
                                              logic [VW-1:0] v);
    coo_pkg::req_t a;
    a.action      = act;
    a.row         = r;
    a.col         = c;
    a.write_value = v;
    return a;
  endfunction

  function automatic logic [VW-1:0] rand_value();
    logic [VW-1:0] v;
    case ($urandom_range(7))
      0:       v = '0;
      1:       v = '1;
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  function automatic logic [RW-1:0] rand_coord();
    return RW'($urandom);
  endfunction

  // Mostly pool coordinates, some crossed pairs (row or col alone matches), some fresh
  function automatic coo_pkg::req_t rand_access();
    coo_pkg::req_t a;
    int            pick;
    int            i;
    int            j;
    pick = $urandom_range(99);
    i    = $urandom_range(POOL_N-1);
    j    = $urandom_range(POOL_N-1);
    a.action = $urandom_range(1) ? coo_pkg::ACT_SET : coo_pkg::ACT_GET;
    if (pick < 84) begin
      a.row = pool_row[i];
      a.col = pool_col[i];
    end else if (pick < 92) begin
      a.row = pool_row[i];
      a.col = pool_col[j];
    end else begin
      a.row = rand_coord();
      a.col = rand_coord();
    end
    a.write_value = rand_value();
    return a;
  endfunction

  // Offers one item, with random idle cycles first, and records its answer on acceptance
  task automatic send_access(coo_pkg::req_t a);
    logic [127:0] junk;
    while ($urandom_range(99) < send_idle_pct) begin
      junk       = {$urandom, $urandom, $urandom, $urandom};
      req_valid <= 1'b0;
      req       <= junk[REQ_W-1:0];
      @(posedge clk);
    end
    req       <= a;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    expected_rsp_q.push_back(predict_access(a));
  endtask

  task automatic wait_rsp_drain();
    req_valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic set_idling(int send_pct, int rsp_pct);
    send_idle_pct = send_pct;
    stall_pct    <= rsp_pct;
  endtask

  // Empty table, extremes of coordinates and values, set hit/miss, partial matches
  task automatic test_directed();
    set_idling(0, 0);
    send_access(mk_access(coo_pkg::ACT_GET, 16'hFFFF, 16'hFFFF, '1));
    send_access(mk_access(coo_pkg::ACT_SET, 16'h0000, 16'h0000, '1));
    send_access(mk_access(coo_pkg::ACT_GET, 16'h0000, 16'h0000, '0));
    send_access(mk_access(coo_pkg::ACT_SET, 16'hFFFF, 16'hFFFF, '0));
    send_access(mk_access(coo_pkg::ACT_GET, 16'hFFFF, 16'hFFFF, 64'h5A5A_5A5A_5A5A_5A5A));
    send_access(mk_access(coo_pkg::ACT_SET, 16'h0000, 16'h0000, 64'h0123_4567_89AB_CDEF));
    send_access(mk_access(coo_pkg::ACT_GET, 16'h0000, 16'h0000, '0));
    send_access(mk_access(coo_pkg::ACT_GET, 16'h0000, 16'hFFFF, '0));
    send_access(mk_access(coo_pkg::ACT_GET, 16'hFFFF, 16'h0000, '0));
    send_access(mk_access(coo_pkg::ACT_SET, 16'h0000, 16'hFFFF, 64'h8000_0000_0000_0001));
    send_access(mk_access(coo_pkg::ACT_SET, 16'hFFFF, 16'h0000, 64'hAAAA_AAAA_AAAA_AAAA));
    send_access(mk_access(coo_pkg::ACT_GET, 16'hFFFF, 16'h0000, '1));
    send_access(mk_access(coo_pkg::ACT_GET, 16'h0000, 16'hFFFF, '0));
    send_access(mk_access(coo_pkg::ACT_SET, 16'h5555, 16'hAAAA, 64'h5555_5555_5555_5555));
    send_access(mk_access(coo_pkg::ACT_SET, 16'hAAAA, 16'h5555, 64'hFEDC_BA98_7654_3210));
    send_access(mk_access(coo_pkg::ACT_GET, 16'h5555, 16'hAAAA, '0));
    send_access(mk_access(coo_pkg::ACT_GET, 16'hAAAA, 16'h5555, '0));
    send_access(mk_access(coo_pkg::ACT_SET, 16'hFFFF, 16'hFFFF, '1));
    send_access(mk_access(coo_pkg::ACT_GET, 16'hFFFF, 16'hFFFF, '0));
    send_access(mk_access(coo_pkg::ACT_GET, 16'h5555, 16'h5555, '0));
  endtask

  task automatic test_random(int n, int send_pct, int rsp_pct);
    int i;
    set_idling(send_pct, rsp_pct);
    for (i = 0; i < n; i++) send_access(rand_access());
  endtask

  // Receiver holds off long enough for the unit to stall its input, then full drain
  task automatic test_rsp_backpressure();
    int i;
    set_idling(0, 0);
    hold_req_cnt <= hold_req_cnt + 1;
    for (i = 0; i < 10; i++) send_access(rand_access());
    wait_rsp_drain();
  endtask

  // Append fresh coordinates until the table holds CAP entries
  task automatic test_fill();
    set_idling(35, 35);
    while (tbl_cnt < CAP)
      send_access(mk_access(coo_pkg::ACT_SET, rand_coord(), rand_coord(), rand_value()));
  endtask

  // Full table: refused appends, updates and reads down to the last entry
  task automatic test_full();
    int i;
    int k;
    set_idling(0, 0);
    send_access(mk_access(coo_pkg::ACT_SET, tbl_row[CAP-1], tbl_col[CAP-1], '1));
    send_access(mk_access(coo_pkg::ACT_GET, tbl_row[CAP-1], tbl_col[CAP-1], '0));
    send_access(mk_access(coo_pkg::ACT_SET, rand_coord(), rand_coord(), '1));
    send_access(mk_access(coo_pkg::ACT_GET, tbl_row[0], tbl_col[0], '0));
    set_idling(35, 35);
    for (i = 0; i < 36; i++) begin
      k = $urandom_range(CAP-1);
      case ($urandom_range(3))
        0: send_access(mk_access(coo_pkg::ACT_SET, rand_coord(), rand_coord(), rand_value()));
        1: send_access(mk_access(coo_pkg::ACT_SET, tbl_row[k], tbl_col[k], rand_value()));
        2: send_access(mk_access(coo_pkg::ACT_GET, tbl_row[k], tbl_col[k], rand_value()));
        default: begin
          send_access(mk_access(coo_pkg::ACT_GET, rand_coord(), rand_coord(), rand_value()));
        end
      endcase
    end
  endtask

  // Receiver: random stalls plus a long hold-off when requested
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (hold_req_cnt != hold_seen) begin
        hold_seen = hold_req_cnt;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        rsp_stall <= 1'b1;
        hold_left--;
      end else begin
        rsp_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_rsp
    coo_pkg::rsp_t exp_rsp;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsp_q.size() == 0) begin
        $error("result with no item pending: %h", rsp);
        error_cnt++;
      end else begin
        exp_rsp = expected_rsp_q.pop_front();
        if (rsp.read_value !== exp_rsp.read_value) begin
          $error("read_value: expected %h, got %h", exp_rsp.read_value, rsp.read_value);
          error_cnt++;
        end
        if (rsp.found !== exp_rsp.found) begin
          $error("found: expected %b, got %b", exp_rsp.found, rsp.found);
          error_cnt++;
        end
        if (rsp.table_full !== exp_rsp.table_full) begin
          $error("table_full: expected %b, got %b", exp_rsp.table_full, rsp.table_full);
          error_cnt++;
        end
        if (rsp.entry_count !== exp_rsp.entry_count) begin
          $error("entry_count: expected %0d, got %0d", exp_rsp.entry_count, rsp.entry_count);
          error_cnt++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : run_tests
    int i;
    pool_row[0] = 16'h0000; pool_col[0] = 16'h0000;
    pool_row[1] = 16'hFFFF; pool_col[1] = 16'hFFFF;
    pool_row[2] = 16'h0000; pool_col[2] = 16'hFFFF;
    pool_row[3] = 16'hFFFF; pool_col[3] = 16'h0000;
    for (i = 4; i < POOL_N; i++) begin
      pool_row[i] = rand_coord();
      pool_col[i] = rand_coord();
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_random(340, 0, 0);
    test_random(340, 70, 0);
    test_rsp_backpressure();
    test_random(340, 0, 70);
    test_random(340, 35, 35);
    test_fill();
    test_full();

    wait_rsp_drain();
    repeat (SETTLE_CYC) @(posedge clk);
    if (error_cnt == 0 && expected_rsp_q.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/coo_pkg.sv
rtl/coo_ram.sv
rtl/coo_ctrl.sv
rtl/coo_sparse_entry_table_unit.sv
sim/tb.sv
